@@ design/flow_leak_window_valve_lock_assert.svh @@
// Assertion macros shared by the flow leak window valve lock modules.
`ifndef FLOW_LEAK_WINDOW_VALVE_LOCK_ASSERT_SVH
`define FLOW_LEAK_WINDOW_VALVE_LOCK_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FLWV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FLWV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/flwv_pkg.sv @@
// Package: types, constants and codes of the flow leak window valve lock.
`default_nettype none

package flwv_pkg;

   localparam int RING_SLOTS       = 256;
   localparam int SAMPLE_PERIOD_MS = 1000;
   localparam int MS_PER_SEC       = 1000;

   localparam int OP_W       = 3;
   localparam int PULSE_W    = 16;
   localparam int MASK_W     = 2;
   localparam int VALVE_W    = 2;
   localparam int THR_W      = 16;
   localparam int SEC_W      = 16;
   localparam int DURATION_W = 27;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;

   localparam int PTR_W  = $clog2(RING_SLOTS);
   localparam int CNT_W  = $clog2(RING_SLOTS + 1);
   localparam int ADDR_W = PTR_W + 2;
   localparam int SUM_W  = PULSE_W + CNT_W;
   localparam int SPAN_W = SEC_W + $clog2(MS_PER_SEC + 1);
   localparam int END_W  = $clog2((RING_SLOTS + 1) * SAMPLE_PERIOD_MS + 1);
   localparam int CMP_W  = (SPAN_W > END_W) ? SPAN_W : END_W;

   localparam logic [OP_W-1:0] OP_CAPTURE  = 3'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd1;
   localparam logic [OP_W-1:0] OP_UNLOCK   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
   localparam logic [OP_W-1:0] OP_REEVAL   = 3'd4;

   localparam logic [VALVE_W-1:0] VALVE_NONE  = 2'd0;
   localparam logic [VALVE_W-1:0] VALVE_OPEN  = 2'd1;
   localparam logic [VALVE_W-1:0] VALVE_CLOSE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LEAK1_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK1_WINDOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK2_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK2_WINDOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_DURATION   = 3'd4;

   localparam logic [THR_W-1:0]      RST_LEAK1_THRESHOLD = 16'd100;
   localparam logic [SEC_W-1:0]      RST_LEAK1_WINDOW    = 16'd10;
   localparam logic [THR_W-1:0]      RST_LEAK2_THRESHOLD = 16'd1000;
   localparam logic [SEC_W-1:0]      RST_LEAK2_WINDOW    = 16'd60;
   localparam logic [DURATION_W-1:0] RST_TEMP_DURATION   = 27'd60000;

   localparam logic ALERT_TEMP = 1'b0;
   localparam logic ALERT_PERM = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PULSE_W-1:0] pulse_count;
      logic [MASK_W-1:0]  unlock_mask;
   } flwv_req_type;

   typedef struct packed {
      logic [VALVE_W-1:0] valve_command;
      logic               temp_locked;
      logic               perm_locked;
      logic               leak1_since_report;
      logic               leak2_since_report;
   } flwv_rsp_type;

   typedef struct packed {
      logic latch;
      logic exec_op;
      logic walk_start;
      logic walk_sel;
      logic walk_step;
      logic drive;
      logic load_rsp;
   } flwv_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            temp_locked;
      logic            perm_locked;
      logic            walk_done;
   } flwv_stat_type;

endpackage

`default_nettype wire

@@ design/flwv_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module flwv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/flwv_ctrl.sv @@
// Controller: sequences op execution, the two window walks and the result beat.
`default_nettype none

`include "flow_leak_window_valve_lock_assert.svh"

module flwv_ctrl
   import flwv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire flwv_stat_type stat,
   output flwv_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_START1,
      ST_WALK1,
      ST_START2,
      ST_WALK2,
      ST_DRIVE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.latch = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.exec_op = 1'b1;
            if (stat.op == OP_CAPTURE || stat.op == OP_REEVAL) begin
               state_in = ST_START1;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_START1: begin
            if (stat.temp_locked) begin
               state_in = ST_START2;
            end else begin
               cmd.walk_start = 1'b1;
               cmd.walk_sel   = ALERT_TEMP;
               state_in       = ST_WALK1;
            end
         end
         ST_WALK1: begin
            cmd.walk_step = 1'b1;
            cmd.walk_sel  = ALERT_TEMP;
            if (stat.walk_done) begin
               state_in = ST_START2;
            end
         end
         ST_START2: begin
            if (stat.perm_locked) begin
               state_in = ST_DRIVE;
            end else begin
               cmd.walk_start = 1'b1;
               cmd.walk_sel   = ALERT_PERM;
               state_in       = ST_WALK2;
            end
         end
         ST_WALK2: begin
            cmd.walk_step = 1'b1;
            cmd.walk_sel  = ALERT_PERM;
            if (stat.walk_done) begin
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            cmd.drive = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FLWV_ASSERT_NOW(a_load_free, cmd.load_rsp, !rsp_valid_ff || rsp_ready, "result overwritten")
   `FLWV_ASSERT_NOW(a_idle_no_walk, req_ready, !cmd.walk_step && !cmd.walk_start, "walk while idle")
   `FLWV_ASSERT_NEXT(a_walk1_exit, state_ff == ST_WALK1 && stat.walk_done,
                     state_ff == ST_START2, "alert 1 walk did not hand over")
   `FLWV_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == ST_DECODE,
                     "accepted beat not decoded")

endmodule

`default_nettype wire

@@ design/flwv_datapath.sv @@
// Datapath: registers, capture ring, window walker, lock flags and valve command.
`default_nettype none

`include "flow_leak_window_valve_lock_assert.svh"

module flwv_datapath
   import flwv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire flwv_req_type          req_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire flwv_cmd_type          cmd,
   output flwv_stat_type              stat,
   output flwv_rsp_type               rsp_data
);

   localparam logic [ADDR_W-1:0] SLOTS_X = ADDR_W'(RING_SLOTS);

   logic [THR_W-1:0]      leak1_threshold_ff;
   logic [SEC_W-1:0]      leak1_window_ff;
   logic [THR_W-1:0]      leak2_threshold_ff;
   logic [SEC_W-1:0]      leak2_window_ff;
   logic [DURATION_W-1:0] temp_duration_ff;

   logic [OP_W-1:0]    op_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic [MASK_W-1:0]  mask_ff;

   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [CNT_W-1:0]      stored_ff, stored_in;
   logic                  temp_ff, temp_in;
   logic                  perm_ff, perm_in;
   logic [DURATION_W-1:0] elapsed_ff, elapsed_in;
   logic                  alert1_ff, alert1_in;
   logic                  alert2_ff, alert2_in;
   logic                  closed_ff, closed_in;
   logic                  known_ff, known_in;
   logic [VALVE_W-1:0]    valve_ff, valve_in;
   flwv_rsp_type          rsp_ff;

   logic               walk_sel_ff, walk_sel_in;
   logic [CNT_W-1:0]   walk_k_ff, walk_k_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [END_W-1:0]   end_ff, end_in;
   logic [SPAN_W-1:0]  span_ff, span_in;

   logic                  ram_wr;
   logic [ADDR_W-1:0]     rd_dist;
   logic [PTR_W-1:0]      rd_addr;
   logic [PULSE_W-1:0]    rd_data;
   logic                  win_ok;
   logic                  walk_done;
   logic                  walk_trip;
   logic [THR_W-1:0]      thr_sel;
   logic [SEC_W-1:0]      sec_sel;
   logic                  drive_en;
   logic                  drive_want;
   logic [DURATION_W-1:0] elapsed_inc;

   flwv_ram #(
      .WIDTH (PULSE_W),
      .DEPTH (RING_SLOTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wp_ff),
      .wr_data (pulse_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         leak1_threshold_ff <= RST_LEAK1_THRESHOLD;
         leak1_window_ff    <= RST_LEAK1_WINDOW;
         leak2_threshold_ff <= RST_LEAK2_THRESHOLD;
         leak2_window_ff    <= RST_LEAK2_WINDOW;
         temp_duration_ff   <= RST_TEMP_DURATION;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LEAK1_THRESHOLD: leak1_threshold_ff <= csr_data[THR_W-1:0];
            CSR_LEAK1_WINDOW:    leak1_window_ff    <= csr_data[SEC_W-1:0];
            CSR_LEAK2_THRESHOLD: leak2_threshold_ff <= csr_data[THR_W-1:0];
            CSR_LEAK2_WINDOW:    leak2_window_ff    <= csr_data[SEC_W-1:0];
            CSR_TEMP_DURATION:   temp_duration_ff   <= csr_data[DURATION_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      thr_sel = (walk_sel_ff == ALERT_PERM) ? leak2_threshold_ff : leak1_threshold_ff;
      sec_sel = (cmd.walk_sel == ALERT_PERM) ? leak2_window_ff : leak1_window_ff;
      win_ok  = (walk_k_ff == '0) ||
                ((walk_k_ff < CNT_W'(RING_SLOTS)) &&
                 (CMP_W'(end_ff) <= CMP_W'(span_ff)));
      walk_done = !win_ok || (walk_k_ff >= stored_ff) || (rd_data == '0);
      walk_trip = !win_ok && (sum_ff >= SUM_W'(thr_sel));
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   end

   always_comb begin
      wp_in       = wp_ff;
      stored_in   = stored_ff;
      temp_in     = temp_ff;
      perm_in     = perm_ff;
      elapsed_in  = elapsed_ff;
      alert1_in   = alert1_ff;
      alert2_in   = alert2_ff;
      closed_in   = closed_ff;
      known_in    = known_ff;
      valve_in    = valve_ff;
      walk_sel_in = walk_sel_ff;
      walk_k_in   = walk_k_ff;
      sum_in      = sum_ff;
      end_in      = end_ff;
      span_in     = span_ff;
      ram_wr      = 1'b0;
      drive_en    = 1'b0;
      drive_want  = 1'b0;

      if (cmd.exec_op) begin
         valve_in = VALVE_NONE;
         unique case (op_ff)
            OP_CAPTURE: begin
               ram_wr = 1'b1;
               wp_in  = (wp_ff == PTR_W'(RING_SLOTS - 1)) ? '0 : wp_ff + 1'b1;
               if (stored_ff < CNT_W'(RING_SLOTS)) begin
                  stored_in = stored_ff + 1'b1;
               end
            end
            OP_TICK: begin
               if (temp_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= temp_duration_ff) begin
                     temp_in    = 1'b0;
                     drive_en   = 1'b1;
                     drive_want = perm_ff;
                  end
               end
            end
            OP_UNLOCK: begin
               temp_in    = temp_ff && !mask_ff[0];
               perm_in    = perm_ff && !mask_ff[1];
               drive_en   = 1'b1;
               drive_want = (temp_ff && !mask_ff[0]) || (perm_ff && !mask_ff[1]);
            end
            OP_CLEAR: begin
               alert1_in = 1'b0;
               alert2_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.walk_start) begin
         walk_sel_in = cmd.walk_sel;
         walk_k_in   = '0;
         sum_in      = '0;
         end_in      = END_W'(SAMPLE_PERIOD_MS);
         span_in     = SPAN_W'(sec_sel) * SPAN_W'(MS_PER_SEC);
      end else if (cmd.walk_step) begin
         if (!walk_done) begin
            walk_k_in = walk_k_ff + 1'b1;
            sum_in    = sum_ff + SUM_W'(rd_data);
            end_in    = end_ff + END_W'(SAMPLE_PERIOD_MS);
         end else if (walk_trip) begin
            if (walk_sel_ff == ALERT_TEMP) begin
               temp_in    = 1'b1;
               elapsed_in = '0;
               alert1_in  = 1'b1;
            end else begin
               perm_in   = 1'b1;
               alert2_in = 1'b1;
            end
         end
      end

      if (cmd.drive) begin
         drive_en   = 1'b1;
         drive_want = temp_ff || perm_ff;
      end

      if (drive_en) begin
         known_in  = 1'b1;
         closed_in = drive_want;
         if (!known_ff) begin
            valve_in = drive_want ? VALVE_CLOSE : VALVE_NONE;
         end else if (drive_want != closed_ff) begin
            valve_in = drive_want ? VALVE_CLOSE : VALVE_OPEN;
         end else begin
            valve_in = VALVE_NONE;
         end
      end
   end

   always_comb begin
      rd_dist = ADDR_W'(wp_ff) + SLOTS_X - 1'b1 - ADDR_W'(walk_k_in);
      if (rd_dist >= SLOTS_X) begin
         rd_dist = rd_dist - SLOTS_X;
      end
      rd_addr = rd_dist[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         stored_ff  <= '0;
         temp_ff    <= 1'b0;
         perm_ff    <= 1'b0;
         elapsed_ff <= '0;
         alert1_ff  <= 1'b0;
         alert2_ff  <= 1'b0;
         closed_ff  <= 1'b0;
         known_ff   <= 1'b0;
         walk_k_ff  <= '0;
      end else begin
         wp_ff      <= wp_in;
         stored_ff  <= stored_in;
         temp_ff    <= temp_in;
         perm_ff    <= perm_in;
         elapsed_ff <= elapsed_in;
         alert1_ff  <= alert1_in;
         alert2_ff  <= alert2_in;
         closed_ff  <= closed_in;
         known_ff   <= known_in;
         walk_k_ff  <= walk_k_in;
      end
   end

   always_ff @(posedge clock) begin
      valve_ff    <= valve_in;
      walk_sel_ff <= walk_sel_in;
      sum_ff      <= sum_in;
      end_ff      <= end_in;
      span_ff     <= span_in;
      if (cmd.latch) begin
         op_ff    <= req_data.op;
         pulse_ff <= req_data.pulse_count;
         mask_ff  <= req_data.unlock_mask;
      end
      if (cmd.load_rsp) begin
         rsp_ff.valve_command      <= valve_ff;
         rsp_ff.temp_locked        <= temp_ff;
         rsp_ff.perm_locked        <= perm_ff;
         rsp_ff.leak1_since_report <= alert1_ff;
         rsp_ff.leak2_since_report <= alert2_ff;
      end
   end

   assign stat.op          = op_ff;
   assign stat.temp_locked = temp_ff;
   assign stat.perm_locked = perm_ff;
   assign stat.walk_done   = walk_done;
   assign rsp_data         = rsp_ff;

   `FLWV_ASSERT_NOW(a_walk_bound, 1'b1, walk_k_ff <= CNT_W'(RING_SLOTS), "walk ran past ring")
   `FLWV_ASSERT_NOW(a_walk_stored, cmd.walk_step && !walk_done, walk_k_ff < stored_ff,
                    "walk read unwritten slot")
   `FLWV_ASSERT_NOW(a_stored_cap, 1'b1, stored_ff <= CNT_W'(RING_SLOTS), "stored count past ring")

endmodule

`default_nettype wire

@@ design/flow_leak_window_valve_lock.sv @@
// Top level: flow leak window alerts with temporary and permanent valve locks.
//
// Usage: each req beat carries an op (capture, ms tick, unlock, clear flags,
// re-evaluate), a pulse count and an unlock mask; each req beat yields exactly
// one rsp beat with the valve command and the lock and since-report flags.
// The csr channel writes one of five registers by index; csr_ready is always
// high and writes belong to idle periods. An index beyond the list is dropped.
// Ticks, unlocks and flag clears go from req accept through decode to the
// rsp register. Captures and re-evaluations add two backward walks over the
// capture ring, one ring entry per cycle through the ring's registered read
// port, and a valve drive step before the rsp register; each walk sums at
// most RING_SLOTS entries.
// A walk is skipped while its own lock is set. One item is in work at a time;
// req_ready is high only while the controller is idle.
// Reset clears the pointers, locks, flags and valve history and loads the
// register defaults; the ring needs no clearing. A stalled rsp beat holds in
// the output register; the next req beat is still taken and worked, and its
// result waits until the stalled beat leaves.
`default_nettype none

module flow_leak_window_valve_lock
   import flwv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire flwv_req_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output flwv_rsp_type               rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   flwv_cmd_type  cmd;
   flwv_stat_type stat;

   assign csr_ready = 1'b1;

   flwv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   flwv_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
